>>> rtl/core/time_proportioning_valve_window_macros.svh
// ----------------------------------------------------------------------------
// time proportioning valve window: assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef TIME_PROPORTIONING_VALVE_WINDOW_MACROS_SVH
`define TIME_PROPORTIONING_VALVE_WINDOW_MACROS_SVH

// condition implies consequence in the same cycle
`define TPVW_ASSERT_SAME(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define TPVW_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/tpvw_pkg.sv
// ----------------------------------------------------------------------------
// tpvw_pkg
// types, constants and the remainder step shared by the valve window block
// ----------------------------------------------------------------------------
`default_nettype none

package tpvw_pkg;

    localparam int TIME_BITS = 32;
    localparam int TW        = TIME_BITS;
    localparam int WIN_W     = 16;
    localparam int PH_W      = 14;
    localparam int ADDR_W    = 4;

    localparam logic [WIN_W-1:0] BANG_BANG_ON_MS = WIN_W'(10000);

    localparam logic [1:0] REG_TARGET_PH = 2'd0;
    localparam logic [1:0] REG_USE_PID   = 2'd1;
    localparam logic [1:0] REG_WINDOW    = 2'd2;
    localparam logic [1:0] REG_MIN_OPEN  = 2'd3;

    typedef struct packed {
        logic [PH_W-1:0]  target_ph_milli;
        logic             use_pid;
        logic [WIN_W-1:0] window_ms;
        logic [WIN_W-1:0] min_open_ms;
    } t_cfg;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

    // one restoring step: shift in a dividend bit, subtract the divisor if it fits
    function automatic logic [WIN_W-1:0] rem_step(input logic [WIN_W-1:0] rem,
                                                  input logic b,
                                                  input logic [WIN_W-1:0] d);
        logic [WIN_W:0] t;
        t = {rem, b};
        if (t >= {1'b0, d}) begin
            t = t - {1'b0, d};
        end
        return t[WIN_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/tpvw_cfg.sv
// ----------------------------------------------------------------------------
// tpvw_cfg
// apb register file: target ph, pid select, window length, minimum open time
// ----------------------------------------------------------------------------
`default_nettype none

module tpvw_cfg
    import tpvw_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_psel,
    input  wire logic              i_penable,
    input  wire logic              i_pwrite,
    input  wire logic [ADDR_W-1:0] i_paddr,
    input  wire logic [31:0]       i_pwdata,
    output logic      [31:0]       o_prdata,
    output logic                   o_pready,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;
    logic w_wr;

    assign w_wr     = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_ph_milli <= PH_W'(8100);
            r_cfg.use_pid         <= 1'b0;
            r_cfg.window_ms       <= WIN_W'(10000);
            r_cfg.min_open_ms     <= WIN_W'(100);
        end else if (w_wr) begin
            unique case (i_paddr[3:2])
                REG_TARGET_PH: r_cfg.target_ph_milli <= i_pwdata[PH_W-1:0];
                REG_USE_PID:   r_cfg.use_pid         <= i_pwdata[0];
                REG_WINDOW:    r_cfg.window_ms       <= i_pwdata[WIN_W-1:0];
                REG_MIN_OPEN:  r_cfg.min_open_ms     <= i_pwdata[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (i_paddr[3:2])
            REG_TARGET_PH: o_prdata = 32'(r_cfg.target_ph_milli);
            REG_USE_PID:   o_prdata = 32'(r_cfg.use_pid);
            REG_WINDOW:    o_prdata = 32'(r_cfg.window_ms);
            REG_MIN_OPEN:  o_prdata = 32'(r_cfg.min_open_ms);
            default:       o_prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/tpvw_rem.sv
// ----------------------------------------------------------------------------
// tpvw_rem
// iterative remainder unit: time value modulo window, two bits per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module tpvw_rem
    import tpvw_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_div_ctl         i_ctl,
    input  wire logic [TW-1:0]    i_dividend,
    input  wire logic [WIN_W-1:0] i_divisor,
    output t_div_sts              o_sts,
    output logic      [WIN_W-1:0] o_rem
);

    localparam int DW    = TW + (TW % 2);
    localparam int STEPS = DW / 2;
    localparam int CW    = $clog2(STEPS + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DW-1:0]    r_dvd;
    logic [WIN_W-1:0] r_dsr;
    logic [WIN_W-1:0] r_rem;
    logic [WIN_W-1:0] w_rem_a;
    logic [WIN_W-1:0] w_rem_b;

    assign w_rem_a = rem_step(r_rem, r_dvd[DW-1], r_dsr);
    assign w_rem_b = rem_step(w_rem_a, r_dvd[DW-2], r_dsr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_dvd <= DW'(i_dividend);
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DW-3:0], 2'b00};
            r_rem <= w_rem_b;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_rem      = r_rem;

endmodule

`default_nettype wire

>>> rtl/core/time_proportioning_valve_window.sv
// ----------------------------------------------------------------------------
// time_proportioning_valve_window
// time proportioning valve control: demand, window catch-up, switch report
//
// channel   dir  transfer on          payload
// s (in)    in   i_s_tvalid&o_s_tready now, ph, pid on-time; tuser calibration
// m (out)   out  o_m_tvalid&i_m_tready valve open, changed, ms since switch
// apb cfg   in   psel&penable&pwrite   four registers at 4*i
//
// an update goes from idle straight to finish when the window needs no catch-up, else
// through a catch-up step, where the remainder unit retires two dividend bits per cycle
// reset is synchronous and clears window start, valve state and switch time
// the result sits in an output register, a new update is taken while it waits
// a finished update holds in its last step until the output register is free
// ----------------------------------------------------------------------------
`default_nettype none

module time_proportioning_valve_window
    import tpvw_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // in: now_ms[31:0], ph_milli[45:32], pid_on_time[61:46], zero pad
    input  wire logic [63:0]       i_s_tdata,
    // in: in_calibration[0]
    input  wire logic              i_s_tuser,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    // out: valve_open[0], changed[1], ms_since_switch[33:2], zero pad
    output logic      [39:0]       o_m_tdata,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    input  wire logic              i_psel,
    input  wire logic              i_penable,
    input  wire logic              i_pwrite,
    input  wire logic [ADDR_W-1:0] i_paddr,
    input  wire logic [31:0]       i_pwdata,
    output logic      [31:0]       o_prdata,
    output logic                   o_pready
);

`include "time_proportioning_valve_window_macros.svh"

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    t_cfg             w_cfg;
    t_div_ctl         w_div_ctl;
    t_div_sts         w_div_sts;
    logic [WIN_W-1:0] w_rem;

    logic [1:0]       r_state;
    logic [TW-1:0]    r_now;
    logic [PH_W-1:0]  r_ph;
    logic [WIN_W-1:0] r_pid;
    logic             r_calib;
    logic [TW-1:0]    r_elapsed;
    logic [TW-1:0]    r_ws;
    logic [TW-1:0]    r_lst;
    logic             r_valve;
    logic             r_out_valid;
    logic [39:0]      r_out_data;

    logic             w_accept;
    logic [WIN_W-1:0] w_win;
    logic [TW-1:0]    w_now_in;
    logic [TW-1:0]    w_elapsed_in;
    logic             w_long;
    logic [TW-1:0]    w_elapsed_div;
    logic [WIN_W-1:0] w_demand;
    logic             w_next;
    logic             w_out_free;
    logic             w_write;
    logic [TW-1:0]    w_since;

    tpvw_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (w_cfg)
    );

    assign w_win        = (w_cfg.window_ms == '0) ? WIN_W'(1) : w_cfg.window_ms;
    assign w_now_in     = TW'(i_s_tdata[31:0]);
    assign w_elapsed_in = w_now_in - r_ws;
    assign w_long       = w_elapsed_in > TW'(w_win);
    assign w_accept     = i_s_tvalid && o_s_tready;
    assign o_s_tready   = (r_state == ST_IDLE);

    assign w_div_ctl.start = w_accept && w_long;

    tpvw_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_div_ctl),
        .i_dividend (w_elapsed_in - TW'(1)),
        .i_divisor  (w_win),
        .o_sts      (w_div_sts),
        .o_rem      (w_rem)
    );

    assign w_elapsed_div = TW'(w_rem) + TW'(1);

    always_comb begin
        if (w_cfg.use_pid) begin
            w_demand = r_pid;
        end else begin
            w_demand = (r_ph > w_cfg.target_ph_milli) ? BANG_BANG_ON_MS : '0;
        end
    end

    assign w_next     = !r_calib && (w_demand > w_cfg.min_open_ms)
                        && (TW'(w_demand) >= r_elapsed);
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_write    = (r_state == ST_FIN) && w_out_free;
    assign w_since    = r_now - r_lst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ws        <= '0;
            r_lst       <= '0;
            r_valve     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_write) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= w_long ? ST_DIV : ST_FIN;
                    end
                end
                ST_DIV: begin
                    if (w_div_sts.done) begin
                        r_ws    <= r_now - w_elapsed_div;
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (w_out_free) begin
                        r_valve <= w_next;
                        if (w_next != r_valve) begin
                            r_lst <= r_now;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_now     <= w_now_in;
            r_ph      <= i_s_tdata[45:32];
            r_pid     <= i_s_tdata[61:46];
            r_calib   <= i_s_tuser;
            r_elapsed <= w_elapsed_in;
        end else if ((r_state == ST_DIV) && w_div_sts.done) begin
            r_elapsed <= w_elapsed_div;
        end
        if (w_write) begin
            r_out_data[0]    <= w_next;
            r_out_data[1]    <= (w_next != r_valve);
            r_out_data[33:2] <= (w_next != r_valve) ? 32'(w_since) : 32'd0;
            r_out_data[39:34] <= '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    `TPVW_ASSERT_NEXT(a_accept_leaves_idle, w_accept,
        (r_state == ST_DIV) || (r_state == ST_FIN), "update accepted but sequencer idle")
    `TPVW_ASSERT_SAME(a_elapsed_in_window, r_state == ST_FIN,
        r_elapsed <= TW'(w_win), "elapsed time beyond one window after catch-up")
    `TPVW_ASSERT_SAME(a_valve_matches_out, r_out_valid,
        r_valve == r_out_data[0], "valve state differs from pending result")
    `TPVW_ASSERT_SAME(a_div_busy_in_div, w_div_sts.busy,
        r_state == ST_DIV, "remainder unit busy outside catch-up")

endmodule

`default_nettype wire
